// File: sv/dtc_pkg.sv
// Shared types and codes of the dual compare timer.
package dtc_pkg;

    // Request function codes.
    localparam logic [1:0] FUNC_READ  = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_TICK  = 2'd2;

    // Register groups, taken from the upper bits of the slot number.
    // The lowest slot bit selects the low or the high unit.
    localparam logic [2:0] GRP_SETUP   = 3'd0;
    localparam logic [2:0] GRP_COUNT   = 3'd1;
    localparam logic [2:0] GRP_COMPARE = 3'd2;
    localparam logic [2:0] GRP_START   = 3'd3;
    localparam logic [2:0] GRP_RESET   = 3'd4;

    // Bit positions in the setup word.
    localparam int BIT_EN   = 0;
    localparam int BIT_RST  = 1;
    localparam int BIT_IRQ  = 2;
    localparam int BIT_IEM  = 3;
    localparam int BIT_MODE = 4;
    localparam int BIT_ONES = 5;
    localparam int BIT_PEN  = 6;
    localparam int BIT_CCFG = 7;
    localparam int BIT_PVAL = 8;
    localparam int BIT_CASC = 31;

    // One request item.
    typedef struct packed {
        logic [1:0]  func;
        logic [3:0]  reg_slot;
        logic [31:0] write_data;
        logic        ref_edge;
    } req_t;

    // One response item.
    typedef struct packed {
        logic [31:0] read_data;
        logic        irq_low;
        logic        irq_high;
    } rsp_t;

    // Stored single-bit fields of a setup word.
    typedef struct packed {
        logic en;
        logic irq;
        logic iem;
        logic mode;
        logic ones;
        logic pen;
        logic ccfg;
        logic casc;
    } setup_flags_t;

endpackage

// File: sv/dtc_timer.sv
// Timer state and the single-pass update for one request item.
module dtc_timer #(
    parameter int PRESCALE_BITS = 8,
    parameter int COUNT_BITS    = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         fire,
    input  dtc_pkg::req_t item,
    output dtc_pkg::rsp_t result
);

    localparam int PB = PRESCALE_BITS;
    localparam int CB = COUNT_BITS;

    // Architectural state.
    logic [CB-1:0]          count_reg   [2];
    logic [CB-1:0]          compare_reg [2];
    logic [PB-1:0]          pre_reg     [2];
    logic [PB-1:0]          pval_reg    [2];
    logic                   run_reg     [2];
    dtc_pkg::setup_flags_t  flags_reg   [2];

    logic [CB-1:0]          count_next   [2];
    logic [PB-1:0]          pre_next     [2];
    logic                   run_next     [2];

    // Intermediate state after the write or the count step, before the compare check.
    logic [CB-1:0]          cnt_mid  [2];
    logic [CB-1:0]          cmp_mid  [2];
    logic [PB-1:0]          pre_mid  [2];
    logic [PB-1:0]          pval_mid [2];
    logic                   run_mid  [2];
    dtc_pkg::setup_flags_t  flg_mid  [2];
    logic [1:0]             chk;

    logic [1:0]             func;
    logic [2:0]             grp;
    logic                   u;
    logic [31:0]            stored_word [2];
    logic [31:0]            wword;
    dtc_pkg::setup_flags_t  new_flags;
    logic                   joined_wr;
    logic [PB-1:0]          pre_tick [2];
    logic                   step     [2];
    logic [2*CB-1:0]        cat_inc;
    logic                   joined_mid;
    logic                   match_lo;
    logic                   hit_lo;
    logic                   hit_hi;
    logic [31:0]            rd;

    assign func = item.func;
    assign grp  = item.reg_slot[3:1];
    assign u    = item.reg_slot[0];

    // Rebuild the stored setup words, with the stored enable bit.
    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            stored_word[i] = '0;
            stored_word[i][dtc_pkg::BIT_EN]     = flags_reg[i].en;
            stored_word[i][dtc_pkg::BIT_IRQ]    = flags_reg[i].irq;
            stored_word[i][dtc_pkg::BIT_IEM]    = flags_reg[i].iem;
            stored_word[i][dtc_pkg::BIT_MODE]   = flags_reg[i].mode;
            stored_word[i][dtc_pkg::BIT_ONES]   = flags_reg[i].ones;
            stored_word[i][dtc_pkg::BIT_PEN]    = flags_reg[i].pen;
            stored_word[i][dtc_pkg::BIT_CCFG]   = flags_reg[i].ccfg;
            stored_word[i][dtc_pkg::BIT_PVAL +: PB] = pval_reg[i];
            stored_word[i][dtc_pkg::BIT_CASC]   = flags_reg[i].casc;
        end
    end

    // Word that a setup, start or reset write stores, and its decoded flags.
    always_comb
    begin
        case (grp)
            dtc_pkg::GRP_SETUP:
            begin
                wword = item.write_data;
            end
            dtc_pkg::GRP_START:
            begin
                wword = stored_word[u];
                wword[dtc_pkg::BIT_EN] = 1'b1;
            end
            dtc_pkg::GRP_RESET:
            begin
                wword = stored_word[u];
                wword[dtc_pkg::BIT_RST] = 1'b1;
            end
            default:
            begin
                wword = stored_word[u];
            end
        endcase
        new_flags.en   = wword[dtc_pkg::BIT_EN];
        new_flags.irq  = wword[dtc_pkg::BIT_IRQ];
        new_flags.iem  = wword[dtc_pkg::BIT_IEM];
        new_flags.mode = wword[dtc_pkg::BIT_MODE];
        new_flags.ones = wword[dtc_pkg::BIT_ONES];
        new_flags.pen  = wword[dtc_pkg::BIT_PEN];
        new_flags.ccfg = wword[dtc_pkg::BIT_CCFG];
        new_flags.casc = wword[dtc_pkg::BIT_CASC] & ~u;
        // Cascade mode as it stands once the write is done.
        joined_wr = u ? flags_reg[0].casc : new_flags.casc;
    end

    // Per-unit event qualification and prescaler for a tick.
    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            pre_tick[i] = pre_reg[i];
            step[i]     = 1'b0;
            if (run_reg[i] && (!flags_reg[i].ccfg || item.ref_edge))
            begin
                if (flags_reg[i].pen)
                begin
                    if (pre_reg[i] < pval_reg[i])
                    begin
                        pre_tick[i] = pre_reg[i] + PB'(1);
                    end
                    else
                    begin
                        pre_tick[i] = '0;
                        step[i]     = 1'b1;
                    end
                end
                else
                begin
                    step[i] = 1'b1;
                end
            end
        end
    end

    // The joined counter increments as one wide word.
    assign cat_inc = {count_reg[1], count_reg[0]} + (2*CB)'(1);

    // Apply the write or the count step.
    always_comb
    begin
        cnt_mid  = count_reg;
        cmp_mid  = compare_reg;
        pre_mid  = pre_reg;
        pval_mid = pval_reg;
        run_mid  = run_reg;
        flg_mid  = flags_reg;
        chk      = 2'b00;
        case (func)
            dtc_pkg::FUNC_WRITE:
            begin
                if (grp inside {[dtc_pkg::GRP_SETUP:dtc_pkg::GRP_RESET]})
                begin
                    chk = 2'b11;
                    case (grp)
                        dtc_pkg::GRP_SETUP, dtc_pkg::GRP_START, dtc_pkg::GRP_RESET:
                        begin
                            flg_mid[u]  = new_flags;
                            pval_mid[u] = wword[dtc_pkg::BIT_PVAL +: PB];
                            run_mid[u]  = wword[dtc_pkg::BIT_EN];
                            if (wword[dtc_pkg::BIT_RST])
                            begin
                                if (joined_wr)
                                begin
                                    cnt_mid[0] = '0;
                                    cnt_mid[1] = '0;
                                    pre_mid[0] = '0;
                                    pre_mid[1] = '0;
                                end
                                else
                                begin
                                    cnt_mid[u] = '0;
                                    pre_mid[u] = '0;
                                end
                            end
                        end
                        dtc_pkg::GRP_COUNT:
                        begin
                            cnt_mid[u] = item.write_data[CB-1:0];
                        end
                        dtc_pkg::GRP_COMPARE:
                        begin
                            cmp_mid[u] = item.write_data[CB-1:0];
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            dtc_pkg::FUNC_TICK:
            begin
                if (flags_reg[0].casc)
                begin
                    pre_mid[0] = pre_tick[0];
                    if (step[0])
                    begin
                        cnt_mid[0] = cat_inc[CB-1:0];
                        cnt_mid[1] = cat_inc[2*CB-1:CB];
                        chk[0]     = 1'b1;
                    end
                end
                else
                begin
                    for (int i = 0; i < 2; i++)
                    begin
                        pre_mid[i] = pre_tick[i];
                        if (step[i])
                        begin
                            cnt_mid[i] = count_reg[i] + CB'(1);
                            chk[i]     = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // Compare check on the updated state.
    always_comb
    begin
        joined_mid = flg_mid[0].casc;
        if (joined_mid)
        begin
            match_lo = (cnt_mid[0] == cmp_mid[0]) && (cnt_mid[1] == cmp_mid[1]);
        end
        else
        begin
            match_lo = cnt_mid[0] == cmp_mid[0];
        end
        hit_lo = chk[0] && run_mid[0] && match_lo;
        hit_hi = chk[1] && !joined_mid && run_mid[1] && (cnt_mid[1] == cmp_mid[1]);

        count_next = cnt_mid;
        pre_next   = pre_mid;
        run_next   = run_mid;
        if (hit_lo && flg_mid[0].mode)
        begin
            count_next[0] = '0;
            if (joined_mid)
            begin
                count_next[1] = '0;
            end
        end
        if (hit_hi && flg_mid[1].mode)
        begin
            count_next[1] = '0;
        end
        if (hit_lo && flg_mid[0].ones)
        begin
            run_next[0] = 1'b0;
        end
        if (hit_hi && flg_mid[1].ones)
        begin
            run_next[1] = 1'b0;
        end
    end

    // Read data for a bus read; zero for every other item.
    always_comb
    begin
        rd = '0;
        if (func == dtc_pkg::FUNC_READ)
        begin
            case (grp)
                dtc_pkg::GRP_SETUP:
                begin
                    rd = stored_word[u];
                    rd[dtc_pkg::BIT_EN] = run_reg[u];
                end
                dtc_pkg::GRP_COUNT:
                begin
                    rd = 32'(count_reg[u]);
                end
                dtc_pkg::GRP_COMPARE:
                begin
                    rd = 32'(compare_reg[u]);
                end
                default:
                begin
                    rd = '0;
                end
            endcase
        end
    end

    assign result.read_data = rd;
    assign result.irq_low   = hit_lo && flg_mid[0].irq;
    assign result.irq_high  = hit_hi && flg_mid[1].irq;

    // State registers, updated once for each processed item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 2; i++)
            begin
                count_reg[i]   <= '0;
                compare_reg[i] <= '0;
                pre_reg[i]     <= '0;
                pval_reg[i]    <= '0;
                run_reg[i]     <= 1'b0;
                flags_reg[i]   <= '0;
            end
        end
        else if (fire)
        begin
            count_reg   <= count_next;
            compare_reg <= cmp_mid;
            pre_reg     <= pre_next;
            pval_reg    <= pval_mid;
            run_reg     <= run_next;
            flags_reg   <= flg_mid;
        end
    end

endmodule

// File: sv/dtc_obuf.sv
// Result register with valid and stall toward the response channel.
module dtc_obuf (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          load,
    input  dtc_pkg::rsp_t din,
    input  logic          stall,
    output logic          valid,
    output dtc_pkg::rsp_t dout
);

    logic          vld_reg;
    logic          vld_next;
    dtc_pkg::rsp_t data_reg;

    // The item leaves when the consumer does not stall; a new one may load in the same cycle.
    always_comb
    begin
        if (load)
        begin
            vld_next = 1'b1;
        end
        else if (vld_reg && !stall)
        begin
            vld_next = 1'b0;
        end
        else
        begin
            vld_next = vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // Payload register.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= din;
        end
    end

    assign valid = vld_reg;
    assign dout  = data_reg;

endmodule

// File: sv/dual_timer_compare_unit.sv
// Top level of the cascadable dual compare timer.
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid / req_stall | req_item (func, reg_slot, write_data, ref_edge)
//   rsp     | out       | rsp_valid / rsp_stall | rsp_item (read_data, irq_low, irq_high)
//
// Without stalls one item is taken every cycle.
// An item waits in the input register, is processed against the timer
// state, and its response is held in the output register.
// A stalled response holds the input register; once that is full, req_stall rises.
// Reset (rst_n low, asynchronous) clears all counters, compare and setup registers.
module dual_timer_compare_unit #(
    parameter int PRESCALE_BITS = 8,
    parameter int COUNT_BITS    = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  dtc_pkg::req_t req_item,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output dtc_pkg::rsp_t rsp_item
);

    logic          in_vld_reg;
    logic          in_vld_next;
    dtc_pkg::req_t in_item_reg;
    logic          fire;
    logic          accept;
    dtc_pkg::rsp_t result;

    // The held item is processed when the output register is free or draining.
    assign fire      = in_vld_reg && (!rsp_valid || !rsp_stall);
    assign req_stall = in_vld_reg && !fire;
    assign accept    = req_valid && !req_stall;

    always_comb
    begin
        if (accept)
        begin
            in_vld_next = 1'b1;
        end
        else if (fire)
        begin
            in_vld_next = 1'b0;
        end
        else
        begin
            in_vld_next = in_vld_reg;
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg <= in_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_item_reg <= req_item;
        end
    end

    // Timer state and update logic.
    dtc_timer #(
        .PRESCALE_BITS (PRESCALE_BITS),
        .COUNT_BITS    (COUNT_BITS)
    ) u_timer (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (in_item_reg),
        .result (result)
    );

    // Output register.
    dtc_obuf u_obuf (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (fire),
        .din   (result),
        .stall (rsp_stall),
        .valid (rsp_valid),
        .dout  (rsp_item)
    );

`ifndef SYNTHESIS
    // A processed item always shows up as a response in the next cycle.
    a_fire_gives_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> rsp_valid)
        else $error("processed item did not produce a response");

    // Only a bus read returns data.
    a_rd_only_on_read: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (in_item_reg.func != dtc_pkg::FUNC_READ) |=> rsp_item.read_data == '0)
        else $error("read data on a non-read item");

    // A bus read never raises an interrupt.
    a_no_irq_on_read: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (in_item_reg.func == dtc_pkg::FUNC_READ)
            |=> !rsp_item.irq_low && !rsp_item.irq_high)
        else $error("interrupt on a bus read");
`endif

endmodule
